>>> sv/arx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX permutation package
// Shared widths and constants for the 24-word ARX permutation block.
// ----------------------------------------------------------------------------
package arx_pkg;

  localparam int WORDS = 24;
  localparam int PAIRS = 12;

  typedef logic [31:0] word_t;
  typedef logic [63:0] pair_t;

  localparam word_t INJECT_CONST = 32'h1FFF_FFFF;
  localparam int    FWD_ROT      = 11;
  localparam int    BWD_ROT      = 19;
  localparam logic [7:0] ROUNDS_AT_RESET = 8'd100;

endpackage
`default_nettype wire

>>> sv/arx_permutation_24_word.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARX permutation over a 24-word state
// Loads key and nonce into a 24-word state, runs round_count rounds and
// streams the final state out as twelve 64-bit word pairs.
// ----------------------------------------------------------------------------
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | in_valid, in_stall, key/nonce words   | in
//  output   | out_valid, out_stall, word_pair, ...  | out
//  config   | cfg_we, cfg_wdata (round_count)       | in
//
// Each round is a mix step (ST_MIX) for XOR, moves and chi, then the two
// add-rotate chains, which a single 32-bit adder walks one word a cycle. An
// item is loaded, runs round_count rounds and leaves in 12 output transfers.
// Reset is synchronous and returns round_count to 100. A stall on the output
// holds the current pair; one item is worked on at a time.
// ----------------------------------------------------------------------------
module arx_permutation_24_word (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output       logic        in_stall,
  input  wire  logic [63:0] key_words_0_1,
  input  wire  logic [63:0] key_words_2_3,
  input  wire  logic [63:0] key_words_4_5,
  input  wire  logic [63:0] key_words_6_7,
  input  wire  logic [63:0] nonce_words_0_1,
  input  wire  logic [63:0] nonce_words_2_3,
  output       logic        out_valid,
  input  wire  logic        out_stall,
  output       arx_pkg::pair_t word_pair,
  output       logic [3:0]  pair_index,
  output       logic        last_pair,
  input  wire  logic        cfg_we,
  input  wire  logic [7:0]  cfg_wdata
);
  import arx_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MIX   = 3'd1;
  localparam logic [2:0] ST_FWD   = 3'd2;
  localparam logic [2:0] ST_BWD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  state;
  logic [7:0]  round_count;
  logic [7:0]  rounds_left;
  logic [4:0]  step;
  logic [3:0]  out_idx;
  word_t       s [WORDS];
  word_t       mixed [WORDS];
  word_t       t [WORDS];
  word_t       chain_base;
  word_t       chain_prev;
  word_t       chain_sum;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // XOR, row moves, column moves and chi in one pass.
  always_comb begin
    for (int i = 0; i < WORDS; i++) t[i] = s[i];
    t[0] = s[0] ^ INJECT_CONST;
    for (int j = 0; j < 6; j++) begin
      t[6 + j]  = s[6 + (j + 1) % 6];
      t[12 + j] = s[12 + (j + 2) % 6];
      t[18 + j] = s[18 + (j + 3) % 6];
    end
    mixed = t;
    mixed[1]  = t[7];
    mixed[7]  = t[13];
    mixed[13] = t[19];
    mixed[2]  = t[14];
    mixed[8]  = t[20];
    mixed[14] = t[2];
    mixed[19] = t[8];
    mixed[3]  = t[21];
    mixed[9]  = t[3];
    mixed[15] = t[9];
    mixed[21] = t[15];
    mixed[5]  = t[11];
    mixed[11] = t[17];
    mixed[17] = t[23];
    mixed[23] = t[5];
    t = mixed;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 5; j++) begin
        mixed[r * 6 + j] = t[r * 6 + j] ^
          (~t[r * 6 + (j + 1) % 5] & t[r * 6 + (j + 2) % 5]);
      end
    end
  end

  // One word of the chain a cycle. Forward: the state rotates left, s[0] is
  // the word being updated and s[23] the word just updated. Backward: the
  // state rotates right, s[23] is the word being updated and s[0] the word
  // just updated.
  always_comb begin
    if (state == ST_FWD) begin
      chain_base = s[0];
      chain_prev = rotl(s[WORDS - 1], FWD_ROT);
    end else begin
      chain_base = s[WORDS - 1];
      chain_prev = rotl(s[0], BWD_ROT);
    end
    chain_sum = chain_base + chain_prev;
  end

  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = (state == ST_OUT);
  assign word_pair  = {s[1], s[0]};
  assign pair_index = out_idx;
  assign last_pair  = (out_idx == 4'(PAIRS - 1));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= ROUNDS_AT_RESET;
    end else if (cfg_we) begin
      round_count <= cfg_wdata;
    end
  end

  // Sequencer and state shifting.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rounds_left <= '0;
      step        <= '0;
      out_idx     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            s[0] <= 32'd0; s[1] <= 32'd0; s[2] <= 32'd1;
            s[3] <= 32'd2; s[4] <= 32'd3; s[5] <= 32'd4;
            s[6] <= nonce_words_0_1[31:0]; s[7] <= nonce_words_0_1[63:32];
            s[8] <= nonce_words_2_3[31:0]; s[9] <= nonce_words_2_3[63:32];
            s[10] <= 32'd0; s[11] <= 32'd0;
            s[12] <= 32'd0; s[13] <= 32'd0; s[14] <= 32'd0; s[15] <= 32'd0;
            s[16] <= key_words_0_1[31:0]; s[17] <= key_words_0_1[63:32];
            s[18] <= key_words_2_3[31:0]; s[19] <= key_words_2_3[63:32];
            s[20] <= key_words_4_5[31:0]; s[21] <= key_words_4_5[63:32];
            s[22] <= key_words_6_7[31:0]; s[23] <= key_words_6_7[63:32];
            rounds_left <= round_count;
            out_idx     <= '0;
            state       <= (round_count == 8'd0) ? ST_OUT : ST_MIX;
          end
        end
        ST_MIX: begin
          for (int i = 0; i < WORDS; i++) s[i] <= mixed[i];
          step  <= '0;
          state <= ST_FWD;
        end
        ST_FWD: begin
          // Rotate left by one word, replacing the head with its sum.
          for (int i = 0; i < WORDS - 1; i++) s[i] <= s[i + 1];
          s[WORDS - 1] <= chain_sum;
          if (step == 5'(WORDS - 1)) begin
            step  <= '0;
            state <= ST_BWD;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_BWD: begin
          // Rotate right by one word; the updated tail enters at s[0], so
          // after a full pass over all 24 words the state is back in order.
          for (int i = 1; i < WORDS; i++) s[i] <= s[i - 1];
          s[0] <= chain_sum;
          if (step == 5'(WORDS - 1)) begin
            step <= '0;
            if (rounds_left == 8'd1) begin
              state <= ST_OUT;
            end else begin
              rounds_left <= rounds_left - 8'd1;
              state       <= ST_MIX;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            for (int i = 0; i < WORDS - 2; i++) s[i] <= s[i + 2];
            s[WORDS - 2] <= s[0];
            s[WORDS - 1] <= s[1];
            out_idx <= out_idx + 4'd1;
            if (out_idx == 4'(PAIRS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_pair) |=> (state == ST_IDLE))
    else $error("last transfer did not return to idle");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input open while busy");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_index <= 4'(PAIRS - 1)))
    else $error("pair index out of range");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD || state == ST_BWD) |-> (step <= 5'(WORDS - 1)))
    else $error("chain step out of range");
`endif

endmodule
`default_nettype wire
